// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the rising edge of clk, off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every edge
`define CHECK_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: always");
// cons must hold at the next edge after ante
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next");
`else
`define CHECK_ALWAYS(label, cond)
`define CHECK_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/pcdrw_pkg.sv =====
// ----------------------------------------------------------------------------
// pcdrw_pkg
// Shared types, codes and helpers of the port command decoder / RFFE writer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdrw_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_REG = 1'd1;
  localparam logic [3:0] SLAVE_ID_RESET   = 4'd6;
  localparam logic [4:0] TARGET_REG_RESET = 5'd1;

  // register-write command field
  localparam logic [2:0] CMD_REG_WRITE = 3'b010;

  // state saturation
  localparam logic [6:0] STATE_MAX      = 7'd64;
  localparam logic [7:0] STATE_MAX_CODE = 8'h60;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DAC    = 2'd0,
    KIND_START  = 2'd1,
    KIND_BIT    = 2'd2,
    KIND_SWITCH = 2'd3
  } kind_t;

  // frame sequencer positions
  localparam int SEQ_W = 5;
  localparam logic [SEQ_W-1:0] IDX_DAC       = 5'd0;
  localparam logic [SEQ_W-1:0] IDX_START     = 5'd1;
  localparam logic [SEQ_W-1:0] IDX_HDR_FIRST = 5'd2;
  localparam logic [SEQ_W-1:0] IDX_HDR_LAST  = 5'd14;
  localparam logic [SEQ_W-1:0] IDX_WRD_FIRST = 5'd15;
  localparam logic [SEQ_W-1:0] IDX_WRD_LAST  = 5'd24;
  localparam logic [SEQ_W-1:0] IDX_SWITCH    = 5'd25;

  localparam int HDR_BITS = 13;
  localparam int WRD_BITS = 10;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one decoded command
  typedef struct packed {
    logic [7:0]          dac;
    logic [1:0]          ldo;       // main, aux
    logic [5:0]          sw_fields;
    logic [WRD_BITS-1:0] word1;
    logic [WRD_BITS-1:0] word2;
    logic                err;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic state_over(input logic [6:0] s);
    return s > STATE_MAX;
  endfunction

  function automatic logic [7:0] state_code(input logic [6:0] s);
    logic [7:0] c;
    if (s >= STATE_MAX) c = STATE_MAX_CODE;
    else                c = {1'b0, s};
    return c;
  endfunction

  // data byte, odd parity, bus park
  function automatic logic [WRD_BITS-1:0] make_word(input logic [7:0] c);
    return {c, ~^c, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcdrw_front.sv =====
// ----------------------------------------------------------------------------
// pcdrw_front
// Five-step byte parser; builds one command per complete sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdrw_front
  import pcdrw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] port_byte,
  output logic            push,
  output cmd_t            cmd
);

  typedef enum logic [2:0] {
    ST_SWITCH = 3'd0,
    ST_DAC_LO = 3'd1,
    ST_POWER  = 3'd2,
    ST_FIRST  = 3'd3,
    ST_SECOND = 3'd4
  } step_t;

  step_t      step;
  logic [5:0] sw_fields;
  logic [5:0] dac_low;
  logic [5:0] power;
  logic [6:0] first_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_SWITCH;
    end else if (accept) begin
      case (step)
        ST_SWITCH: if (port_byte[7:6] == 2'b11) step <= ST_DAC_LO;
        ST_DAC_LO: if (port_byte[7:6] == 2'b10) step <= ST_POWER;
        ST_POWER:  if (port_byte[7:6] == 2'b01) step <= ST_FIRST;
        ST_FIRST:  if (port_byte[7]) step <= ST_SECOND;
        ST_SECOND: if (!port_byte[7]) step <= ST_SWITCH;
        default:   step <= ST_SWITCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (step == ST_SWITCH && port_byte[7:6] == 2'b11) sw_fields <= port_byte[5:0];
      if (step == ST_DAC_LO && port_byte[7:6] == 2'b10) dac_low <= port_byte[5:0];
      if (step == ST_POWER && port_byte[7:6] == 2'b01) power <= port_byte[5:0];
      if (step == ST_FIRST && port_byte[7]) first_state <= port_byte[6:0];
    end
  end

  assign push = accept && (step == ST_SECOND) && !port_byte[7];

  always_comb begin
    cmd.dac       = {power[3:2], dac_low};
    cmd.ldo       = power[1:0];
    cmd.sw_fields = sw_fields;
    cmd.word1     = make_word(state_code(first_state));
    cmd.word2     = make_word(state_code(port_byte[6:0]));
    cmd.err       = state_over(first_state) || state_over(port_byte[6:0]);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcdrw_queue.sv =====
// ----------------------------------------------------------------------------
// pcdrw_queue
// Short command queue between the parser and the frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pcdrw_queue
  import pcdrw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output q_head_t   head,
  output logic      full
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head = '{valid: (count != '0), cmd: mem[rd_ptr]};

  `CHECK_ALWAYS(a_no_overflow, !(push && full))
  `CHECK_ALWAYS(a_no_underflow, !(pop && !head.valid))
  `CHECK_ALWAYS(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/pcdrw_back.sv =====
// ----------------------------------------------------------------------------
// pcdrw_back
// Frame sequencer: DAC update, start, 23 serial bits, switch update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pcdrw_back
  import pcdrw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] slave_id,
  input  wire logic [4:0] target_register,
  input  wire q_head_t    head,
  output logic            pop,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [1:0]      kind,
  output logic [7:0]      dac_code,
  output logic            main_ldo_on,
  output logic            aux_ldo_on,
  output logic            first_switch_a,
  output logic            first_switch_b,
  output logic            second_switch_a,
  output logic            second_switch_b,
  output logic            data_line_one,
  output logic            data_line_two,
  output logic            range_error,
  output logic            last
);

  logic [SEQ_W-1:0]    idx;
  logic                advance;
  logic                fire;
  logic [11:0]         hdr_body;
  logic [HDR_BITS-1:0] header;
  logic [3:0]          hdr_sel;
  logic [3:0]          wrd_sel;
  kind_t               kind_next;
  logic                d1_next;
  logic                d2_next;

  assign advance = !out_valid || !out_stall;
  assign fire    = advance && head.valid;
  assign pop     = fire && (idx == IDX_SWITCH);

  assign hdr_body = {slave_id, CMD_REG_WRITE, target_register};
  assign header   = {hdr_body, ~^hdr_body};
  assign hdr_sel  = 4'(IDX_HDR_LAST - idx);
  assign wrd_sel  = 4'(IDX_WRD_LAST - idx);

  always_comb begin
    kind_next = KIND_BIT;
    d1_next   = 1'b0;
    d2_next   = 1'b0;
    case (idx) inside
      IDX_DAC:   kind_next = KIND_DAC;
      IDX_START: kind_next = KIND_START;
      [IDX_HDR_FIRST:IDX_HDR_LAST]: begin
        d1_next = header[hdr_sel];
        d2_next = header[hdr_sel];
      end
      [IDX_WRD_FIRST:IDX_WRD_LAST]: begin
        d1_next = head.cmd.word1[wrd_sel];
        d2_next = head.cmd.word2[wrd_sel];
      end
      default:   kind_next = KIND_SWITCH;
    endcase
  end

  // sequencer and the levels that persist between frames
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      idx             <= IDX_DAC;
      dac_code        <= '0;
      main_ldo_on     <= 1'b0;
      aux_ldo_on      <= 1'b0;
      first_switch_a  <= 1'b0;
      first_switch_b  <= 1'b0;
      second_switch_a <= 1'b0;
      second_switch_b <= 1'b0;
    end else if (advance) begin
      out_valid <= head.valid;
      if (head.valid) begin
        idx <= (idx == IDX_SWITCH) ? IDX_DAC : idx + 1'b1;
        if (idx == IDX_DAC) begin
          dac_code    <= head.cmd.dac;
          main_ldo_on <= head.cmd.ldo[1];
          aux_ldo_on  <= head.cmd.ldo[0];
        end
        if (idx == IDX_SWITCH) begin
          // a code with its low bit set keeps the old levels
          if (!head.cmd.sw_fields[3]) begin
            first_switch_a <= head.cmd.sw_fields[5];
            first_switch_b <= head.cmd.sw_fields[4];
          end
          if (!head.cmd.sw_fields[0]) begin
            second_switch_a <= head.cmd.sw_fields[2];
            second_switch_b <= head.cmd.sw_fields[1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind          <= kind_next;
      data_line_one <= d1_next;
      data_line_two <= d2_next;
      range_error   <= head.cmd.err;
      last          <= (idx == IDX_SWITCH);
    end
  end

  `CHECK_ALWAYS(a_last_is_switch, !(out_valid && last) || kind == KIND_SWITCH)
  `CHECK_ALWAYS(a_lines_quiet, !(out_valid && kind != KIND_BIT) ||
                (!data_line_one && !data_line_two))
  `CHECK_NEXT(a_pop_rewinds, pop, idx == IDX_DAC)

endmodule

`default_nettype wire

// ===== hw/rtl/port_command_decoder_rffe_writer_top.sv =====
// ----------------------------------------------------------------------------
// port_command_decoder_rffe_writer_top
// Host-port command decoder driving a DAC, two regulators, two RF switches
// and an RFFE register-write frame on two data lines.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-entry command queue has room;
// bytes that do not fit the current parse step are dropped. Each completed
// command produces 26 result words from the frame sequencer, one per cycle
// when the output is not stalled, so the frame sequencer, not the parser,
// bounds the sustained byte rate for well-formed commands. The user must
// write slave_id and target_register only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module port_command_decoder_rffe_writer_top
  import pcdrw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            port_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 kind,
  output logic [7:0]                 dac_code,
  output logic                       main_ldo_on,
  output logic                       aux_ldo_on,
  output logic                       first_switch_a,
  output logic                       first_switch_b,
  output logic                       second_switch_a,
  output logic                       second_switch_b,
  output logic                       data_line_one,
  output logic                       data_line_two,
  output logic                       range_error,
  output logic                       last
);

  logic [3:0] slave_id;
  logic [4:0] target_register;
  logic       q_full;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  q_head_t    head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id        <= SLAVE_ID_RESET;
      target_register <= TARGET_REG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SLAVE_ID:   slave_id        <= wr_data[3:0];
        CFG_TARGET_REG: target_register <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  pcdrw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_valid && !in_stall),
    .port_byte (port_byte),
    .push      (push),
    .cmd       (push_cmd)
  );

  pcdrw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full)
  );

  pcdrw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .slave_id        (slave_id),
    .target_register (target_register),
    .head            (head),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kind            (kind),
    .dac_code        (dac_code),
    .main_ldo_on     (main_ldo_on),
    .aux_ldo_on      (aux_ldo_on),
    .first_switch_a  (first_switch_a),
    .first_switch_b  (first_switch_b),
    .second_switch_a (second_switch_a),
    .second_switch_b (second_switch_b),
    .data_line_one   (data_line_one),
    .data_line_two   (data_line_two),
    .range_error     (range_error),
    .last            (last)
  );

endmodule

`default_nettype wire
